// File: src/smlp_pkg.sv
// Shared types and constants for the stereo four-channel mixer with low-pass filter.
// Holds the word layouts, register indexes, sequencer step codes and the output clamp.
// No dependencies.
`default_nettype none

package smlp_pkg;

	localparam int NUM_CH    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int MUL_A_W   = 14;
	localparam int MUL_B_W   = 16;
	localparam int MUL_P_W   = 31;
	localparam int ACC_W     = 13;
	localparam int Y_W       = 16;

	localparam logic [15:0] VOL_UNITY   = 16'd16384;
	localparam logic [14:0] ALPHA_RESET = 15'd4351;
	localparam logic [15:0] OUT_GAIN    = 16'd40;

	// Step codes of the sequencer. Steps 0..3 scale the left channels and
	// steps 4..7 the right channels.
	localparam logic [3:0] STEP_FLT_L = 4'd8;
	localparam logic [3:0] STEP_FLT_R = 4'd9;
	localparam logic [3:0] STEP_OUT_L = 4'd10;
	localparam logic [3:0] STEP_OUT_R = 4'd11;
	localparam logic [3:0] STEP_LAST  = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOL0,
		REG_VOL1,
		REG_VOL2,
		REG_VOL3,
		REG_MUTE_MASK,
		REG_MASTER_MUTE,
		REG_ALPHA
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [7:0] ch0_left;
		logic signed [7:0] ch1_left;
		logic signed [7:0] ch2_left;
		logic signed [7:0] ch3_left;
		logic signed [7:0] ch0_right;
		logic signed [7:0] ch1_right;
		logic signed [7:0] ch2_right;
		logic signed [7:0] ch3_right;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] left_pcm;
		logic signed [15:0] right_pcm;
	} mix_t;

	typedef struct packed {
		logic [NUM_CH-1:0][15:0] vol;
		logic [NUM_CH-1:0]       mute_mask;
		logic                    master_mute;
		logic [14:0]             alpha;
	} cfg_t;

	// Clamp a product to the signed 16-bit output range.
	function automatic logic signed [15:0] sat16(input logic signed [MUL_P_W-1:0] v);
		logic signed [15:0] r;
		if (v > 32767) begin
			r = 16'sh7FFF;
		end else if (v < -32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/smlp_mul.sv
// Shared multiplier of the mixer: signed 14-bit by unsigned 16-bit, product registered.
// Depends on smlp_pkg.
`default_nettype none

module smlp_mul import smlp_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0]        b,
	output logic signed [MUL_P_W-1:0]      p_q
);

	logic signed [MUL_B_W:0] b_s;

	assign b_s = $signed({1'b0, b});

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a * b_s);
		end
	end

endmodule

`default_nettype wire

// File: src/smlp_cfg.sv
// Configuration register file of the mixer: volumes, mute controls and filter coefficient.
// Depends on smlp_pkg.
`default_nettype none

module smlp_cfg import smlp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 we,
	input  wire logic [CFG_IDX_W-1:0] index,
	input  wire logic [CFG_DAT_W-1:0] wdata,
	output cfg_t                      cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vol         <= {NUM_CH{VOL_UNITY}};
			cfg_q.mute_mask   <= '0;
			cfg_q.master_mute <= 1'b0;
			cfg_q.alpha       <= ALPHA_RESET;
		end else if (we) begin
			// An index past the last register is ignored.
			unique case (index)
				REG_VOL0:        cfg_q.vol[0]      <= wdata;
				REG_VOL1:        cfg_q.vol[1]      <= wdata;
				REG_VOL2:        cfg_q.vol[2]      <= wdata;
				REG_VOL3:        cfg_q.vol[3]      <= wdata;
				REG_MUTE_MASK:   cfg_q.mute_mask   <= wdata[NUM_CH-1:0];
				REG_MASTER_MUTE: cfg_q.master_mute <= wdata[0];
				REG_ALPHA:       cfg_q.alpha       <= wdata[14:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/stereo_mixer_lowpass_core.sv
// Top level of the stereo four-channel mixer with single-pole low-pass filter.
// Depends on smlp_pkg, smlp_cfg and smlp_mul.
`default_nettype none

// The block takes one stereo frame word (four signed 8-bit samples per side),
// scales each sample by its Q2.14 channel volume with truncation toward zero,
// drops muted channels, sums each side and runs the sum through the filter
// y += (alpha * (x - y)) >>> 15. It returns one word holding y * 40 per side,
// clamped to signed 16 bits, or zero while master mute is set; the filters
// keep running under master mute. All arithmetic goes through one registered
// multiplier that a step sequencer uses twelve times per frame: eight volume
// scalings, two filter updates and two output gains. After acceptance the
// sequencer issues these steps in order, then drains the last product in
// a final step, and a done state loads the result into the output register.
// It then returns to idle, so no new frame word is taken before the
// previous frame's result has been handed over. The frame input is ready only
// while the sequencer is idle, but a finished result waiting in the output
// register does not hold off the next frame; only when that next frame is done
// and the output register is still full does the sequencer wait for it to be
// taken. Configuration writes take effect at once and are meant to happen while
// no frame is in flight.
module stereo_mixer_lowpass_core import smlp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frame_valid,
	output logic                      frame_ready,
	input  wire frame_t               frame,
	output logic                      mix_valid,
	input  wire logic                 mix_ready,
	output mix_t                      mix,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

	cfg_t                      cfg_q;
	state_t                    state_q, state_d;
	logic [3:0]                cnt_q;
	frame_t                    frame_q;
	logic signed [7:0]         samp [2*NUM_CH];
	logic signed [8:0]         samp_ext;
	logic [8:0]                samp_mag;
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [MUL_P_W-1:0] prod_q;
	logic                      sign_q;
	logic [3:0]                prev_step;
	logic [9:0]                scaled_mag;
	logic signed [9:0]         scaled;
	logic signed [9:0]         contrib;
	logic signed [ACC_W-1:0]   acc_l_q, acc_r_q;
	logic signed [Y_W-1:0]     y_l_q, y_r_q;
	logic signed [15:0]        res_l_q, res_r_q;
	logic                      out_free;
	logic                      mix_valid_q;
	mix_t                      mix_q;

	smlp_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.wdata (cfg_wdata),
		.cfg_q (cfg_q)
	);

	// Samples in step order: left channels first, then right channels.
	assign samp[0] = frame_q.ch0_left;
	assign samp[1] = frame_q.ch1_left;
	assign samp[2] = frame_q.ch2_left;
	assign samp[3] = frame_q.ch3_left;
	assign samp[4] = frame_q.ch0_right;
	assign samp[5] = frame_q.ch1_right;
	assign samp[6] = frame_q.ch2_right;
	assign samp[7] = frame_q.ch3_right;

	// The multiplier sees the magnitude of a sample, so that dropping the low
	// fraction bits truncates toward zero once the sign is put back.
	assign samp_ext = {samp[cnt_q[2:0]][7], samp[cnt_q[2:0]]};
	assign samp_mag = samp_ext[8] ? 9'(-samp_ext) : 9'(samp_ext);

	// Operand selection for the step being issued.
	always_comb begin
		mul_en = (state_q == ST_RUN) && (cnt_q < STEP_LAST);
		mul_a  = '0;
		mul_b  = '0;
		priority if (cnt_q < STEP_FLT_L) begin
			mul_a = MUL_A_W'(samp_mag);
			mul_b = cfg_q.vol[cnt_q[1:0]];
		end else if (cnt_q == STEP_FLT_L) begin
			mul_a = MUL_A_W'(acc_l_q) - y_l_q[MUL_A_W-1:0];
			mul_b = MUL_B_W'(cfg_q.alpha);
		end else if (cnt_q == STEP_FLT_R) begin
			mul_a = MUL_A_W'(acc_r_q) - y_r_q[MUL_A_W-1:0];
			mul_b = MUL_B_W'(cfg_q.alpha);
		end else if (cnt_q == STEP_OUT_L) begin
			mul_a = y_l_q[MUL_A_W-1:0];
			mul_b = OUT_GAIN;
		end else if (cnt_q == STEP_OUT_R) begin
			mul_a = y_r_q[MUL_A_W-1:0];
			mul_b = OUT_GAIN;
		end else begin
		end
	end

	smlp_mul u_mul (
		.clk(clk),
		.en (mul_en),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(prod_q)
	);

	// The product issued in the previous step is consumed in this one.
	assign prev_step  = cnt_q - 4'd1;
	assign scaled_mag = {1'b0, prod_q[22:14]};
	assign scaled     = sign_q ? -$signed(scaled_mag) : $signed(scaled_mag);
	assign contrib    = cfg_q.mute_mask[prev_step[1:0]] ? 10'sd0 : scaled;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The output register is free when empty or emptied in this cycle.
	assign out_free = !mix_valid_q || mix_ready;

	always_comb begin
		state_d     = state_q;
		frame_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == STEP_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Step counter and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			y_l_q <= '0;
			y_r_q <= '0;
		end else if (frame_valid && frame_ready) begin
			cnt_q <= '0;
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q != '0 && prev_step == STEP_FLT_L) begin
				y_l_q <= y_l_q + prod_q[MUL_P_W-1:15];
			end
			if (cnt_q != '0 && prev_step == STEP_FLT_R) begin
				y_r_q <= y_r_q + prod_q[MUL_P_W-1:15];
			end
		end
	end

	// Frame capture, side sums and per-side results.
	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			frame_q <= frame;
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (mul_en) begin
				sign_q <= samp_ext[8];
			end
			if (cnt_q != '0) begin
				if (prev_step < 4'd4) begin
					acc_l_q <= acc_l_q + ACC_W'(contrib);
				end else if (prev_step < STEP_FLT_L) begin
					acc_r_q <= acc_r_q + ACC_W'(contrib);
				end else if (prev_step == STEP_OUT_L) begin
					res_l_q <= cfg_q.master_mute ? 16'sd0 : sat16(prod_q);
				end else if (prev_step == STEP_OUT_R) begin
					res_r_q <= cfg_q.master_mute ? 16'sd0 : sat16(prod_q);
				end
			end
		end
	end

	// Output register: holds the finished word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			mix_valid_q <= 1'b1;
		end else if (mix_ready) begin
			mix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			mix_q.left_pcm  <= res_l_q;
			mix_q.right_pcm <= res_r_q;
		end
	end

	assign mix_valid = mix_valid_q;
	assign mix       = mix_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q <= STEP_LAST)
		else $error("step counter ran past the last step");

	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == STEP_LAST) |=> state_q == ST_DONE)
		else $error("sequencer did not finish after the last step");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_ready) |=> (state_q == ST_RUN && cnt_q == '0))
		else $error("accepted frame did not start at the first step");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output word appeared without a finished frame");

	a_filter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(y_l_q >= -2048 && y_l_q <= 2047 && y_r_q >= -2048 && y_r_q <= 2047))
		else $error("filter state left its bounded range");
`endif

endmodule

`default_nettype wire
